FILE: src/mrbe_pkg.sv
package mrbe_pkg;

    localparam logic [1:0] CFG_SYNC_VALUE  = 2'd0;
    localparam logic [1:0] CFG_FIRST_WAIT  = 2'd1;
    localparam logic [1:0] CFG_POLL_WAIT   = 2'd2;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [7:0] BTN_MASK   = 8'hE0;
    localparam logic [7:0] BTN_MIDDLE = 8'h40;
    localparam logic [7:0] BTN_NONE   = 8'h00;
    localparam logic [7:0] BTN_BOTH   = 8'hA0;

    localparam logic [7:0] SYNC_RESET       = 8'd128;
    localparam logic [7:0] FIRST_WAIT_RESET = 8'd4;
    localparam logic [7:0] POLL_WAIT_RESET  = 8'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       report_end;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT_FIRST,
        ST_FIX_FLAGS,
        ST_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic emit_step;
        logic fix_flags;
    } ctrl_cmd_t;

    typedef struct packed {
        logic report_full;
        logic tick_emit;
        logic dec_two;
        logic dec_emit;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/mrbe_ctrl.sv
module mrbe_ctrl
    import mrbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && status.report_full) begin
                    state_next = ST_DECODE;
                end else if (s_valid && status.tick_emit) begin
                    state_next = ST_EMIT_LAST;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (status.dec_two) begin
                    state_next = ST_EMIT_FIRST;
                end else if (status.dec_emit) begin
                    state_next = ST_EMIT_LAST;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_FIRST: begin
                cmd.emit_step = status.out_free;
                if (status.out_free && status.idx_last) begin
                    state_next = ST_FIX_FLAGS;
                end
            end
            ST_FIX_FLAGS: begin
                cmd.fix_flags = 1'b1;
                state_next    = ST_EMIT_LAST;
            end
            ST_EMIT_LAST: begin
                cmd.emit_step = status.out_free;
                if (status.out_free && status.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/mrbe_dp.sv
module mrbe_dp
    import mrbe_pkg::*;
#(
    parameter int REPORT_BYTES = 4,
    parameter int FLAGS_INDEX  = 1
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  in_item_t   s_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int STORE_DEPTH = (FLAGS_INDEX + 1 > REPORT_BYTES) ? FLAGS_INDEX + 1
                                                                   : REPORT_BYTES;
    localparam int SIW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW  = $clog2(REPORT_BYTES);
    localparam logic [SIW-1:0] FIDX    = SIW'(FLAGS_INDEX);
    localparam logic [CW-1:0]  IDX_END = CW'(REPORT_BYTES - 1);

    logic [7:0]    sync_reg, first_wait_reg, poll_wait_reg;
    logic [7:0]    store_reg [STORE_DEPTH];
    logic [CW-1:0] collected_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]    pend_reg;
    logic [2:0]    prev_reg;
    logic [2:0]    hold_reg;
    logic [7:0]    count_reg;
    logic          armed_reg;
    logic          m_valid_reg;
    out_item_t     m_data_reg;

    logic [7:0] flags;
    logic [7:0] last_b, nb_raw, nb_dec, nb_fin;
    logic [1:0] pend_dec;
    logic       arm_dec, disarm_dec, two_dec;
    logic       take_byte, expiring;

    assign flags = store_reg[FIDX];

    always_comb begin
        last_b     = {prev_reg, 5'b0};
        nb_raw     = flags & BTN_MASK;
        nb_dec     = (nb_raw == BTN_BOTH) ? BTN_MIDDLE : nb_raw;
        nb_fin     = nb_dec;
        pend_dec   = pend_reg;
        arm_dec    = 1'b0;
        disarm_dec = 1'b0;
        two_dec    = 1'b0;
        if (pend_reg == 2'd0 && last_b != nb_dec) begin
            if (last_b == BTN_MIDDLE && nb_dec != BTN_NONE) begin
                nb_fin = BTN_MIDDLE;
            end else if (last_b == BTN_NONE && nb_dec != BTN_MIDDLE) begin
                arm_dec  = 1'b1;
                pend_dec = 2'd1;
            end
        end else if (pend_reg != 2'd0 && last_b == nb_dec) begin
            if (pend_reg >= 2'd2) begin
                pend_dec   = 2'd0;
                disarm_dec = 1'b1;
            end else begin
                pend_dec = pend_reg + 2'd1;
                arm_dec  = 1'b1;
            end
        end else if (pend_reg != 2'd0) begin
            disarm_dec = 1'b1;
            pend_dec   = 2'd0;
            two_dec    = (nb_dec == BTN_NONE);
        end
    end

    assign take_byte = (s_data.byte_in == sync_reg) || (collected_reg != '0);
    assign expiring  = armed_reg && (count_reg <= 8'd1);

    always_comb begin
        status.report_full = (s_data.op == OP_BYTE) && take_byte && (collected_reg == IDX_END);
        status.tick_emit   = (s_data.op == OP_TICK) && expiring
                             && (pend_reg == 2'd0 || pend_reg >= 2'd2);
        status.dec_two     = two_dec;
        status.dec_emit    = (pend_dec == 2'd0);
        status.idx_last    = (idx_reg == IDX_END);
        status.out_free    = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg       <= SYNC_RESET;
            first_wait_reg <= FIRST_WAIT_RESET;
            poll_wait_reg  <= POLL_WAIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SYNC_VALUE: sync_reg       <= cfg_wdata;
                CFG_FIRST_WAIT: first_wait_reg <= cfg_wdata;
                CFG_POLL_WAIT:  poll_wait_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            collected_reg <= '0;
            pend_reg      <= '0;
            prev_reg      <= '0;
            hold_reg      <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
        end else begin
            if (cmd.accept && s_data.op == OP_BYTE && take_byte) begin
                store_reg[SIW'(collected_reg)] <= s_data.byte_in;
                collected_reg <= (collected_reg == IDX_END) ? '0 : collected_reg + 1'b1;
            end
            if (cmd.accept && s_data.op == OP_TICK && armed_reg) begin
                if (expiring) begin
                    if (pend_reg == 2'd1) begin
                        pend_reg  <= 2'd2;
                        count_reg <= poll_wait_reg;
                        armed_reg <= 1'b1;
                    end else begin
                        pend_reg  <= 2'd0;
                        count_reg <= '0;
                        armed_reg <= 1'b0;
                    end
                end else begin
                    count_reg <= count_reg - 8'd1;
                end
            end
            if (cmd.decode) begin
                pend_reg <= pend_dec;
                if (arm_dec) begin
                    count_reg <= first_wait_reg;
                    armed_reg <= 1'b1;
                end else if (disarm_dec) begin
                    armed_reg <= 1'b0;
                end
                prev_reg <= nb_fin[7:5];
                hold_reg <= nb_fin[7:5];
                store_reg[FIDX] <= {two_dec ? last_b[7:5] : nb_fin[7:5], flags[4:0]};
            end
            if (cmd.fix_flags) begin
                store_reg[FIDX] <= {hold_reg, flags[4:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else if (cmd.emit_step) begin
            m_valid_reg           <= 1'b1;
            m_data_reg.byte_out   <= store_reg[SIW'(idx_reg)];
            m_data_reg.report_end <= (idx_reg == IDX_END);
            idx_reg               <= (idx_reg == IDX_END) ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/mouse_report_button_emulator.sv
// Mouse report framer with two-button middle emulation. Each received byte or
// timer tick is accepted while the sequencer is idle. A byte that completes a
// report passes through a decode state; a report that is emitted, after decode
// or on an expiring tick, then goes out one byte per cycle through the single
// output register while the sink does not hold m_ready low. A release during a
// pending press emits two reports with a flags-rewrite state between them.
// Input is held off (s_ready low) from decode, or from an emitting tick, until
// the last report byte is loaded into the output register.
module mouse_report_button_emulator
    import mrbe_pkg::*;
#(
    parameter int REPORT_BYTES = 4,
    parameter int FLAGS_INDEX  = 1
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mrbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mrbe_dp #(
        .REPORT_BYTES (REPORT_BYTES),
        .FLAGS_INDEX  (FLAGS_INDEX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
